/* design/toc_pkg.sv */
// Shared constants, types and tables for the tilt orientation classifier.
package toc_pkg;

    // Angle output format and CORDIC depth
    localparam int ANGLE_FRAC_BITS   = 7;
    localparam int CORDIC_ITERATIONS = 16;

    // Internal fixed point
    localparam int SAMPLE_W   = 16;
    localparam int GUARD_BITS = 8;
    localparam int TABLE_BITS = 20;
    localparam int TABLE_LEN  = 24;
    localparam int CW         = SAMPLE_W + GUARD_BITS + 3;  // x/y datapath, headroom for gain
    localparam int ZW         = 30;                         // angle accumulator, deg * 2^20
    localparam int ROUND_SH   = TABLE_BITS - ANGLE_FRAC_BITS;

    // 1/K in Q0.16 for gain compensation
    localparam int             GAIN_SH  = 16;
    localparam logic [GAIN_SH-1:0] INV_GAIN = 16'd39797;
    localparam int             PW       = CW + GAIN_SH + 1;

    // Field widths
    localparam int PITCH_W = 15;
    localparam int ROLL_W  = 16;
    localparam int VLIM_W  = 8;
    localparam int HLIM_W  = 8;
    localparam int GLIM_W  = 16;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VERTICAL_LIMIT   = 2'd0,
        CFG_HORIZONTAL_LIMIT = 2'd1,
        CFG_GYRO_LIMIT       = 2'd2
    } t_cfg_idx;

    localparam logic [VLIM_W-1:0] VLIM_RESET = 8'd60;
    localparam logic [HLIM_W-1:0] HLIM_RESET = 8'd30;
    localparam logic [GLIM_W-1:0] GLIM_RESET = 16'd300;

    typedef logic signed [ZW-1:0] t_angle;

    // atan(2^-i) in degrees * 2^20
    localparam t_angle ATAN_TAB [TABLE_LEN] = '{
        30'sd47185920, 30'sd27855475, 30'sd14718068, 30'sd7471121,
        30'sd3750058,  30'sd1876857,  30'sd938658,   30'sd469357,
        30'sd234682,   30'sd117342,   30'sd58671,    30'sd29335,
        30'sd14668,    30'sd7334,     30'sd3667,     30'sd1833,
        30'sd917,      30'sd458,      30'sd229,      30'sd115,
        30'sd57,       30'sd29,       30'sd14,       30'sd7
    };

    localparam t_angle Z_QUARTER  = t_angle'(longint'(90) << TABLE_BITS);
    localparam t_angle ROUND_HALF = t_angle'(longint'(1) << (ROUND_SH - 1));
    localparam t_angle PITCH_LIM  = t_angle'(longint'(90) << ANGLE_FRAC_BITS);
    localparam t_angle ROLL_LIM   = t_angle'(longint'(180) << ANGLE_FRAC_BITS);

    // Data carried alongside a CORDIC pass
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] ax;
        t_angle                     roll;
        logic                       pitch_motion;
        logic                       roll_motion;
    } t_side;

    // One finished result
    typedef struct packed {
        logic signed [PITCH_W-1:0] pitch_angle;
        logic signed [ROLL_W-1:0]  roll_angle;
        logic                      vertical_flag;
        logic                      horizontal_flag;
        logic                      pitch_motion_flag;
        logic                      roll_motion_flag;
    } t_result;

endpackage

/* design/toc_if.sv */
// Request channels of the tilt orientation classifier: sample input and angle result.
interface toc_in_if import toc_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] accel_x;
    logic signed [SAMPLE_W-1:0] accel_y;
    logic signed [SAMPLE_W-1:0] accel_z;
    logic signed [SAMPLE_W-1:0] gyro_x;
    logic signed [SAMPLE_W-1:0] gyro_y;

    modport source (output valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, input ready);
    modport sink   (input valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, output ready);
endinterface

interface toc_out_if import toc_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [PITCH_W-1:0] pitch_angle;
    logic signed [ROLL_W-1:0]  roll_angle;
    logic                      vertical_flag;
    logic                      horizontal_flag;
    logic                      pitch_motion_flag;
    logic                      roll_motion_flag;

    modport source (output valid, pitch_angle, roll_angle, vertical_flag, horizontal_flag,
                    pitch_motion_flag, roll_motion_flag, input ready);
    modport sink   (input valid, pitch_angle, roll_angle, vertical_flag, horizontal_flag,
                    pitch_motion_flag, roll_motion_flag, output ready);
endinterface

/* design/tilt_orientation_classifier_top.sv */
// Tilt orientation classifier: top level pipeline.
//
// Input channel i_in carries one accelerometer triple and two gyro rates per request.
// Output channel o_out carries pitch and roll in degrees (ANGLE_FRAC_BITS fraction
// bits) with vertical, horizontal and two motion flags. Roll = atan2(ay, az),
// pitch = atan2(-ax, |(ay, az)|), each from a pipelined CORDIC in vectoring mode.
// Throughput: one request per cycle while the output is not held. Every stage
// registers once per cycle; the longest step is one CORDIC micro-rotation or the
// 27x17 gain multiply. Path from acceptance to o_out.valid: input register, two
// CORDICs of one pre-rotation and CORDIC_ITERATIONS stages each, gain multiply,
// gain round, angle round, flag compare, output register.
// Limits are to be written on i_cfg_* only while no request is in flight; the
// block does not enforce this. Reset (synchronous, i_rst_n low) empties the
// pipeline and loads the default limits 60 deg, 30 deg and 300.
// When the receiver stalls, one more result parks in a skid stage; after that
// the whole pipeline holds and i_in.ready drops until the output is taken.
module tilt_orientation_classifier_top import toc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    toc_in_if.sink                i_in,
    toc_out_if.source             o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);
    logic w_en;

    // Configuration registers
    logic [VLIM_W-1:0] r_vlim;
    logic [HLIM_W-1:0] r_hlim;
    logic [GLIM_W-1:0] r_glim;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vlim <= VLIM_RESET;
            r_hlim <= HLIM_RESET;
            r_glim <= GLIM_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_VERTICAL_LIMIT:   r_vlim <= i_cfg_data[VLIM_W-1:0];
                CFG_HORIZONTAL_LIMIT: r_hlim <= i_cfg_data[HLIM_W-1:0];
                CFG_GYRO_LIMIT:       r_glim <= i_cfg_data[GLIM_W-1:0];
                default: ;
            endcase
        end
    end

    assign i_in.ready = w_en;

    // Input register
    logic                       r_s0_v;
    logic signed [SAMPLE_W-1:0] r_s0_ax;
    logic signed [SAMPLE_W-1:0] r_s0_ay;
    logic signed [SAMPLE_W-1:0] r_s0_az;
    logic signed [SAMPLE_W-1:0] r_s0_gx;
    logic signed [SAMPLE_W-1:0] r_s0_gy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_v <= 1'b0;
        end else if (w_en) begin
            r_s0_v  <= i_in.valid;
            r_s0_ax <= i_in.accel_x;
            r_s0_ay <= i_in.accel_y;
            r_s0_az <= i_in.accel_z;
            r_s0_gx <= i_in.gyro_x;
            r_s0_gy <= i_in.gyro_y;
        end
    end

    // Gyro magnitudes against the motion limit
    logic signed [SAMPLE_W:0] w_gx_ext;
    logic signed [SAMPLE_W:0] w_gy_ext;
    logic signed [SAMPLE_W:0] w_gx_abs;
    logic signed [SAMPLE_W:0] w_gy_abs;

    assign w_gx_ext = (SAMPLE_W + 1)'(r_s0_gx);
    assign w_gy_ext = (SAMPLE_W + 1)'(r_s0_gy);
    assign w_gx_abs = w_gx_ext[SAMPLE_W] ? -w_gx_ext : w_gx_ext;
    assign w_gy_abs = w_gy_ext[SAMPLE_W] ? -w_gy_ext : w_gy_ext;

    // Roll CORDIC on (az, ay) with guard bits
    t_side                w_roll_in_side;
    logic signed [CW-1:0] w_roll_x;
    logic signed [CW-1:0] w_roll_y;
    logic                 w_roll_v;
    t_angle               w_roll_z;
    logic signed [CW-1:0] w_roll_mag;
    t_side                w_roll_side;

    assign w_roll_x = CW'(r_s0_az) <<< GUARD_BITS;
    assign w_roll_y = CW'(r_s0_ay) <<< GUARD_BITS;

    always_comb begin
        w_roll_in_side              = '0;
        w_roll_in_side.ax           = r_s0_ax;
        w_roll_in_side.pitch_motion = $unsigned(w_gx_abs) > {1'b0, r_glim};
        w_roll_in_side.roll_motion  = $unsigned(w_gy_abs) > {1'b0, r_glim};
    end

    toc_cordic u_roll_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_s0_v),
        .i_x     (w_roll_x),
        .i_y     (w_roll_y),
        .i_side  (w_roll_in_side),
        .o_valid (w_roll_v),
        .o_angle (w_roll_z),
        .o_mag   (w_roll_mag),
        .o_side  (w_roll_side)
    );

    // Gain compensation: multiply by 1/K
    logic                 r_p_v;
    logic signed [PW-1:0] r_p_prod;
    t_side                r_p_side;
    logic signed [PW-1:0] w_prod;
    t_side                w_p_side;

    assign w_prod = w_roll_mag * $signed({1'b0, INV_GAIN});

    // Roll angle joins the side data here
    always_comb begin
        w_p_side      = w_roll_side;
        w_p_side.roll = w_roll_z;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_v <= 1'b0;
        end else if (w_en) begin
            r_p_v    <= w_roll_v;
            r_p_prod <= w_prod;
            r_p_side <= w_p_side;
        end
    end

    // Round the magnitude and set up the pitch vector (mag, -ax)
    logic                 r_m_v;
    logic signed [CW-1:0] r_m_mag;
    logic signed [CW-1:0] r_m_y;
    t_side                r_m_side;
    logic signed [PW-1:0] w_prod_rnd;

    assign w_prod_rnd = (r_p_prod + (PW'(1) <<< (GAIN_SH - 1))) >>> GAIN_SH;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_v <= 1'b0;
        end else if (w_en) begin
            r_m_v    <= r_p_v;
            r_m_mag  <= w_prod_rnd[CW-1:0];
            r_m_y    <= -(CW'(r_p_side.ax) <<< GUARD_BITS);
            r_m_side <= r_p_side;
        end
    end

    // Pitch CORDIC
    logic                 w_pitch_v;
    t_angle               w_pitch_z;
    logic signed [CW-1:0] w_pitch_mag;
    t_side                w_pitch_side;

    toc_cordic u_pitch_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_m_v),
        .i_x     (r_m_mag),
        .i_y     (r_m_y),
        .i_side  (r_m_side),
        .o_valid (w_pitch_v),
        .o_angle (w_pitch_z),
        .o_mag   (w_pitch_mag),
        .o_side  (w_pitch_side)
    );

    // Round half up to the output fraction, then clamp
    function automatic t_angle f_round_sat(input t_angle z, input t_angle lim);
        t_angle r;
        r = (z + ROUND_HALF) >>> ROUND_SH;
        if (r > lim) begin
            r = lim;
        end else if (r < -lim) begin
            r = -lim;
        end
        return r;
    endfunction

    logic   r_r_v;
    t_angle r_r_pitch;
    t_angle r_r_roll;
    logic   r_r_pm;
    logic   r_r_rm;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r_v <= 1'b0;
        end else if (w_en) begin
            r_r_v     <= w_pitch_v;
            r_r_pitch <= f_round_sat(w_pitch_z, PITCH_LIM);
            r_r_roll  <= f_round_sat(w_pitch_side.roll, ROLL_LIM);
            r_r_pm    <= w_pitch_side.pitch_motion;
            r_r_rm    <= w_pitch_side.roll_motion;
        end
    end

    // Orientation flags
    t_angle  w_ap;
    t_angle  w_ar;
    t_angle  w_vl;
    t_angle  w_hl;
    t_result w_res;

    assign w_ap = r_r_pitch[ZW-1] ? -r_r_pitch : r_r_pitch;
    assign w_ar = r_r_roll[ZW-1]  ? -r_r_roll  : r_r_roll;
    assign w_vl = t_angle'({1'b0, r_vlim}) <<< ANGLE_FRAC_BITS;
    assign w_hl = t_angle'({1'b0, r_hlim}) <<< ANGLE_FRAC_BITS;

    always_comb begin
        w_res.pitch_angle       = r_r_pitch[PITCH_W-1:0];
        w_res.roll_angle        = r_r_roll[ROLL_W-1:0];
        w_res.vertical_flag     = (w_ap > w_vl) || (w_ar > w_vl);
        w_res.horizontal_flag   = (w_ap < w_hl) && (w_ar < w_hl);
        w_res.pitch_motion_flag = r_r_pm;
        w_res.roll_motion_flag  = r_r_rm;
    end

    logic    r_l_v;
    t_result r_l_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_l_v <= 1'b0;
        end else if (w_en) begin
            r_l_v   <= r_r_v;
            r_l_res <= w_res;
        end
    end

    // Output register and skid stage
    toc_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_en & r_l_v),
        .i_data  (r_l_res),
        .o_en    (w_en),
        .o_out   (o_out)
    );

    // A held pipeline means a result is parked at the output
    a_stall_has_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> o_out.valid)
        else $error("pipeline held with no result at the output");

    a_pitch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_r_v |-> (r_r_pitch <= PITCH_LIM) && (r_r_pitch >= -PITCH_LIM))
        else $error("pitch outside +-90 degrees");

    a_roll_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_r_v |-> (r_r_roll <= ROLL_LIM) && (r_r_roll >= -ROLL_LIM))
        else $error("roll outside +-180 degrees");

    // Pitch vector starts in the right half-plane, so its x only grows
    a_pitch_mag_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pitch_v |-> !w_pitch_mag[CW-1])
        else $error("pitch CORDIC magnitude negative");

endmodule

/* design/toc_cordic.sv */
// Pipelined CORDIC vectoring unit: one pre-rotation stage, then one stage per iteration.
module toc_cordic import toc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic signed [CW-1:0] i_x,
    input  logic signed [CW-1:0] i_y,
    input  t_side                i_side,
    output logic                 o_valid,
    output t_angle               o_angle,
    output logic signed [CW-1:0] o_mag,
    output t_side                o_side
);
    localparam int NS = CORDIC_ITERATIONS + 1;

    logic                 r_v    [NS];
    logic signed [CW-1:0] r_x    [NS];
    logic signed [CW-1:0] r_y    [NS];
    t_angle               r_z    [NS];
    logic                 r_zero [NS];
    t_side                r_side [NS];

    logic signed [CW-1:0] n_x0;
    logic signed [CW-1:0] n_y0;
    t_angle               n_z0;

    // Left half-plane vectors are turned by a quarter first
    always_comb begin
        n_x0 = i_x;
        n_y0 = i_y;
        n_z0 = '0;
        if (i_x[CW-1]) begin
            if (!i_y[CW-1]) begin
                n_x0 = i_y;
                n_y0 = -i_x;
                n_z0 = Z_QUARTER;
            end else begin
                n_x0 = -i_y;
                n_y0 = i_x;
                n_z0 = -Z_QUARTER;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0]    <= i_valid;
            r_x[0]    <= n_x0;
            r_y[0]    <= n_y0;
            r_z[0]    <= n_z0;
            r_zero[0] <= (i_x == '0) && (i_y == '0);
            r_side[0] <= i_side;
        end
    end

    // Micro-rotations, fixed shift per stage
    genvar g;
    generate
        for (g = 1; g < NS; g++) begin : g_iter
            logic signed [CW-1:0] n_xs;
            logic signed [CW-1:0] n_ys;
            logic signed [CW-1:0] n_x;
            logic signed [CW-1:0] n_y;
            t_angle               n_z;

            assign n_xs = r_x[g-1] >>> (g - 1);
            assign n_ys = r_y[g-1] >>> (g - 1);

            always_comb begin
                if (!r_y[g-1][CW-1]) begin
                    n_x = r_x[g-1] + n_ys;
                    n_y = r_y[g-1] - n_xs;
                    n_z = r_z[g-1] + ATAN_TAB[g-1];
                end else begin
                    n_x = r_x[g-1] - n_ys;
                    n_y = r_y[g-1] + n_xs;
                    n_z = r_z[g-1] - ATAN_TAB[g-1];
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[g] <= 1'b0;
                end else if (i_en) begin
                    r_v[g]    <= r_v[g-1];
                    r_x[g]    <= n_x;
                    r_y[g]    <= n_y;
                    r_z[g]    <= n_z;
                    r_zero[g] <= r_zero[g-1];
                    r_side[g] <= r_side[g-1];
                end
            end
        end
    endgenerate

    // Zero vector reads as angle 0; its x stays 0 through the stages
    assign o_valid = r_v[NS-1];
    assign o_angle = r_zero[NS-1] ? '0 : r_z[NS-1];
    assign o_mag   = r_x[NS-1];
    assign o_side  = r_side[NS-1];

endmodule

/* design/toc_out_buf.sv */
// Output register with skid stage; parts the pipeline from the result receiver.
module toc_out_buf import toc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_result   i_data,
    output logic      o_en,
    toc_out_if.source o_out
);
    logic    r_out_v;
    logic    r_skid_v;
    t_result r_out_d;
    t_result r_skid_d;
    logic    n_out_v;
    logic    n_skid_v;
    t_result n_out_d;
    t_result n_skid_d;
    logic    w_take;

    // Output register can load when empty or being taken
    assign w_take = !r_out_v || o_out.ready;

    always_comb begin
        if (w_take) begin
            n_out_v  = r_skid_v | i_push;
            n_out_d  = r_skid_v ? r_skid_d : i_data;
            n_skid_v = 1'b0;
            n_skid_d = r_skid_d;
        end else begin
            n_out_v  = r_out_v;
            n_out_d  = r_out_d;
            n_skid_v = r_skid_v | i_push;
            n_skid_d = i_push ? i_data : r_skid_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            r_out_v  <= n_out_v;
            r_skid_v <= n_skid_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_d  <= n_out_d;
        r_skid_d <= n_skid_d;
    end

    // Pipeline moves only while the skid stage is free
    assign o_en = !r_skid_v;

    assign o_out.valid             = r_out_v;
    assign o_out.pitch_angle       = r_out_d.pitch_angle;
    assign o_out.roll_angle        = r_out_d.roll_angle;
    assign o_out.vertical_flag     = r_out_d.vertical_flag;
    assign o_out.horizontal_flag   = r_out_d.horizontal_flag;
    assign o_out.pitch_motion_flag = r_out_d.pitch_motion_flag;
    assign o_out.roll_motion_flag  = r_out_d.roll_motion_flag;

endmodule

/* verif/tilt_orientation_checker.sv */
// Scoreboard for the tilt orientation classifier: predicts each angle result and compares it.
module tilt_orientation_checker import toc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    toc_in_if                     i_in,
    toc_out_if                    i_res,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Fixed point of the angle datapath
    localparam int     Q_DEG     = 20;      // angle accumulator: degrees * 2^20
    localparam int     SHIFT_IN  = 8;       // guard bits on the accel samples
    localparam longint INV_K_Q16 = 39797;   // 1/K of the CORDIC gain
    localparam int     ATAN_LEN  = 24;

    // Limits after reset
    localparam logic [7:0]  VERT_DEFAULT = 8'd60;
    localparam logic [7:0]  HORZ_DEFAULT = 8'd30;
    localparam logic [15:0] GYRO_DEFAULT = 16'd300;

    // atan(2^-i) in degrees * 2^20
    longint atan_deg_q20 [0:ATAN_LEN-1] = '{
        47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
        234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
        917, 458, 229, 115, 57, 29, 14, 7
    };

    logic [7:0]  vert_lim;
    logic [7:0]  horz_lim;
    logic [15:0] gyro_lim;
    t_result     tilt_expected [$];
    int          fail_count;

    assign o_fail_count = fail_count;

    // Vectoring CORDIC: angle of (x, y) in degrees * 2^20, gain_mag gets K * |v|
    function automatic longint vector_angle(longint y_in, longint x_in, output longint gain_mag);
        longint x, y, z, t, xs, ys;
        x = x_in;
        y = y_in;
        z = 0;
        if (x == 0 && y == 0) begin
            gain_mag = 0;
            return 0;
        end
        // left half plane: quarter turn first
        if (x < 0) begin
            if (y >= 0) begin
                t = x; x = y; y = -t; z = longint'(90) << Q_DEG;
            end else begin
                t = x; x = -y; y = t; z = -(longint'(90) << Q_DEG);
            end
        end
        for (int i = 0; i < CORDIC_ITERATIONS && i < ATAN_LEN; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x += ys; y -= xs; z += atan_deg_q20[i];
            end else begin
                x -= ys; y += xs; z -= atan_deg_q20[i];
            end
        end
        gain_mag = x;
        return z;
    endfunction

    // Round half up to the output fraction, then clamp to +-lim_deg
    function automatic longint round_deg(longint z, longint lim_deg);
        longint r, lim;
        r   = (z + (longint'(1) << (Q_DEG - ANGLE_FRAC_BITS - 1))) >>> (Q_DEG - ANGLE_FRAC_BITS);
        lim = lim_deg << ANGLE_FRAC_BITS;
        if (r > lim) r = lim;
        if (r < -lim) r = -lim;
        return r;
    endfunction

    function automatic t_result predict_tilt(logic signed [15:0] ax_raw, logic signed [15:0] ay_raw,
                                             logic signed [15:0] az_raw, logic signed [15:0] gx_raw,
                                             logic signed [15:0] gy_raw);
        longint  ax, ay, az, kmag, mag, spare_mag, roll, pitch, ap, ar, vl, hl, gxa, gya;
        t_result r;
        ax = longint'(ax_raw) << SHIFT_IN;
        ay = longint'(ay_raw) << SHIFT_IN;
        az = longint'(az_raw) << SHIFT_IN;
        roll  = round_deg(vector_angle(ay, az, kmag), 180);
        mag   = (kmag * INV_K_Q16 + 32768) >>> 16;
        pitch = round_deg(vector_angle(-ax, mag, spare_mag), 90);
        ap  = (pitch < 0) ? -pitch : pitch;
        ar  = (roll < 0) ? -roll : roll;
        vl  = longint'(vert_lim) << ANGLE_FRAC_BITS;
        hl  = longint'(horz_lim) << ANGLE_FRAC_BITS;
        gxa = (gx_raw < 0) ? -longint'(gx_raw) : longint'(gx_raw);
        gya = (gy_raw < 0) ? -longint'(gy_raw) : longint'(gy_raw);
        // wide fractions are cut to the field widths, flags use the full values
        r.pitch_angle       = pitch[PITCH_W-1:0];
        r.roll_angle        = roll[ROLL_W-1:0];
        r.vertical_flag     = (ap > vl) || (ar > vl);
        r.horizontal_flag   = (ap < hl) && (ar < hl);
        r.pitch_motion_flag = gxa > longint'(gyro_lim);
        r.roll_motion_flag  = gya > longint'(gyro_lim);
        return r;
    endfunction

    task automatic check_field(string name, longint want, longint got);
        if (want != got) begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    initial fail_count = 0;

    // Track limits, queue predictions per request, compare per result
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            vert_lim = VERT_DEFAULT;
            horz_lim = HORZ_DEFAULT;
            gyro_lim = GYRO_DEFAULT;
            tilt_expected.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_VERTICAL_LIMIT:   vert_lim = i_cfg_data[7:0];
                    CFG_HORIZONTAL_LIMIT: horz_lim = i_cfg_data[7:0];
                    CFG_GYRO_LIMIT:       gyro_lim = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in.valid && i_in.ready)
                tilt_expected.push_back(predict_tilt(i_in.accel_x, i_in.accel_y, i_in.accel_z,
                                                     i_in.gyro_x, i_in.gyro_y));
            if (i_res.valid && i_res.ready) begin
                if (tilt_expected.size() == 0) begin
                    $display("%0t: result with none expected: pitch %0d roll %0d", $time,
                             i_res.pitch_angle, i_res.roll_angle);
                    fail_count++;
                end else begin
                    want = tilt_expected.pop_front();
                    check_field("pitch_angle", want.pitch_angle, i_res.pitch_angle);
                    check_field("roll_angle", want.roll_angle, i_res.roll_angle);
                    check_field("vertical_flag", want.vertical_flag, i_res.vertical_flag);
                    check_field("horizontal_flag", want.horizontal_flag, i_res.horizontal_flag);
                    check_field("pitch_motion_flag", want.pitch_motion_flag,
                                i_res.pitch_motion_flag);
                    check_field("roll_motion_flag", want.roll_motion_flag,
                                i_res.roll_motion_flag);
                end
            end
        end
        o_pending <= tilt_expected.size();
    end

endmodule

/* verif/tilt_orientation_classifier_top_tb.sv */
// Testbench top for the tilt orientation classifier: clock, reset, stimulus and verdict.
module tilt_orientation_classifier_top_tb;
    import toc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 200;
    localparam int SETTLE      = 2 * CORDIC_ITERATIONS + 12;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fail_count;
    int                    pending;
    int                    cycle_count = 0;
    int                    glim = 300;
    bit                    idle_on = 1'b1;
    bit                    hold_rx = 1'b0;

    toc_in_if  in_ch ();
    toc_out_if out_ch ();

    tilt_orientation_classifier_top DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    tilt_orientation_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_res        (out_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #4 i_clk = ~i_clk;

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Result side: random stall bursts, one long hold-off on request
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_rx) begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_rx = 1'b0;
                out_ch.ready <= 1'b1;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge i_clk);
                out_ch.ready <= 1'b1;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Offer one request, with an optional gap first; returns at the accepting edge
    task automatic send_sample(logic [15:0] ax, logic [15:0] ay, logic [15:0] az,
                               logic [15:0] gx, logic [15:0] gy);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.accel_x <= ax;
        in_ch.accel_y <= ay;
        in_ch.accel_z <= az;
        in_ch.gyro_x  <= gx;
        in_ch.gyro_y  <= gy;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    // Stop offering and wait until every predicted result has come back
    task automatic drain();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // Three back-to-back register writes; the pipeline is empty here
    task automatic write_limits(logic [7:0] vert, logic [7:0] horz, logic [15:0] gyro);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_VERTICAL_LIMIT;
        cfg_data <= {8'd0, vert};
        @(posedge i_clk);
        cfg_idx  <= CFG_HORIZONTAL_LIMIT;
        cfg_data <= {8'd0, horz};
        @(posedge i_clk);
        cfg_idx  <= CFG_GYRO_LIMIT;
        cfg_data <= gyro;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        glim = gyro;
    endtask

    function automatic logic [15:0] edge_val();
        case ($urandom_range(0, 5))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            4:       return 16'h0001;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] near(int center, int spread);
        return 16'(center + int'($urandom_range(0, 2 * spread)) - spread);
    endfunction

    // Gyro rates cluster around the motion limit to hit the strict compare
    function automatic logic [15:0] pick_gyro();
        int v;
        case ($urandom_range(0, 4))
            0, 1: begin
                v = glim + int'($urandom_range(0, 2)) - 1;
                if ($urandom_range(0, 1) == 1) v = -v;
                return 16'(v);
            end
            2, 3:    return 16'($urandom);
            default: return edge_val();
        endcase
    endfunction

    task automatic send_random();
        logic [15:0] a [3];
        int          k;
        case ($urandom_range(0, 3))
            0: for (k = 0; k < 3; k++) a[k] = 16'($urandom);
            // sensor at rest: one axis carries gravity, the others small
            1: begin
                for (k = 0; k < 3; k++) a[k] = near(0, 6000);
                k = $urandom_range(0, 2);
                a[k] = near(($urandom_range(0, 1) == 1) ? 16000 : -16000, 3000);
            end
            2: for (k = 0; k < 3; k++) a[k] = near(0, 8);
            default: for (k = 0; k < 3; k++) a[k] = edge_val();
        endcase
        send_sample(a[0], a[1], a[2], pick_gyro(), pick_gyro());
    endtask

    task automatic run_random(int count);
        for (int n = 0; n < count; n++) send_random();
        drain();
    endtask

    // Stimulus
    initial begin
        i_rst_n        <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_idx        <= CFG_VERTICAL_LIMIT;
        cfg_data       <= '0;
        in_ch.valid    <= 1'b0;
        in_ch.accel_x  <= '0;
        in_ch.accel_y  <= '0;
        in_ch.accel_z  <= '0;
        in_ch.gyro_x   <= '0;
        in_ch.gyro_y   <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed requests with the reset limits
        send_sample(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);            // zero vector
        send_sample(16'sd0, 16'sd0, -16'sd100, 16'sd300, -16'sd300);    // roll +180
        send_sample(16'sd0, 16'sd5, -16'sd100, 16'sd301, -16'sd301);    // negative z, y >= 0
        send_sample(16'sd0, -16'sd5, -16'sd100, -16'sd299, 16'sd299);   // negative z, y < 0
        send_sample(16'sd0, -16'sd1, -16'sd32768, 16'sd0, 16'sd0);      // roll overshoot
        send_sample(16'sd0, 16'sd1, -16'sd32768, 16'sd0, 16'sd0);
        send_sample(16'sd32767, 16'sd0, 16'sd0, 16'sd0, 16'sd0);        // pitch -90
        send_sample(-16'sd32768, 16'sd0, 16'sd0, 16'sd0, 16'sd0);       // pitch +90
        send_sample(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768);
        send_sample(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767);
        send_sample(16'sd0, 16'sd32767, 16'sd0, -16'sd32768, 16'sd32767);
        send_sample(16'sd0, -16'sd32768, 16'sd0, 16'sd32767, -16'sd32768);
        send_sample(16'sd0, 16'sd0, 16'sd32767, 16'sd0, 16'sd0);        // flat
        send_sample(16'sd100, 16'sd0, 16'sd16384, 16'sd1, -16'sd1);
        send_sample(16'sd0, 16'sd16384, 16'sd16384, 16'sd0, 16'sd0);    // roll 45
        send_sample(-16'sd16384, 16'sd0, 16'sd16384, 16'sd0, 16'sd0);   // pitch 45
        send_sample(-16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1);
        send_sample(16'sd1, 16'sd1, 16'sd1, 16'sd1, 16'sd1);
        send_sample(16'sd0, 16'sd0, -16'sd1, 16'sd0, 16'sd0);
        send_sample(16'sd0, -16'sd1, 16'sd0, 16'sd0, 16'sd0);
        send_sample(16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
        drain();

        // Low extremes of every limit
        write_limits(8'd0, 8'd0, 16'd0);
        run_random(100);

        // Top of range; receiver holds off so the pipeline backs up
        write_limits(8'd180, 8'd180, 16'd32768);
        hold_rx = 1'b1;
        run_random(100);

        // Beyond range: vertical never set
        write_limits(8'd255, 8'd255, 16'hFFFF);
        run_random(100);

        // A stretch with no idling on either side
        idle_on = 1'b0;
        write_limits(8'd45, 8'd10, 16'd1000);
        run_random(100);
        idle_on = 1'b1;

        for (int p = 0; p < 4; p++) begin
            write_limits(8'($urandom_range(0, 200)), 8'($urandom_range(0, 200)),
                         16'($urandom_range(0, 33000)));
            run_random(100);
        end

        // Closing part without idling, back at the reset limits
        idle_on = 1'b0;
        write_limits(8'd60, 8'd30, 16'd300);
        run_random(130);

        repeat (SETTLE) @(posedge i_clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
